FILE: rtl/ifd_pkg.sv
`timescale 1ns / 1ps

package ifd_pkg;

    // Fixed widths of the line length register and the delay field
    localparam int CFG_W = 13;
    localparam int DLY_W = 20;

    localparam logic [CFG_W-1:0] LINE_LENGTH_RESET = 13'd4096;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_INTERP,
        S_MIX,
        S_FB,
        S_WB
    } state_t;

    typedef struct packed {
        logic ld_s1;
        logic ld_prod;
        logic ld_o;
        logic ld_fb;
    } arith_ctl_t;

endpackage

FILE: rtl/interpolated_feedback_delay_unit.sv
// Fractional delay line with linear interpolation and feedback. Each input word carries a
// sample, a delay in samples with FRAC_BITS fraction bits, and a Q1.15 feedback gain; each
// produces one output word. After reset the block sweeps the delay store to zero, one entry
// a cycle, and holds in_ready low until the sweep is done; line_length writes are taken
// at any time. Each item is written back before the next is accepted: the delay store has
// a single read port, so the two neighboring entries are read in successive cycles, and
// the interpolation multiply, rounding and feedback multiply each get a register stage
// before the write-back. The result sits in an output register; if it has not been taken
// by the time the next item reaches write-back, that item holds there until the output
// frees. A line_length of 0 acts as 1 and a value above DEPTH acts as DEPTH; delays at or
// beyond the line length clamp to the longest one.
`timescale 1ns / 1ps

module interpolated_feedback_delay_unit #(
    parameter int DEPTH       = 4096,
    parameter int FRAC_BITS   = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_BITS-1:0]   in_sample,
    input  logic [ifd_pkg::DLY_W-1:0]       delay_samples,
    input  logic signed [SAMPLE_BITS-1:0]   feedback_gain,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_BITS-1:0]   delayed_sample,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ifd_pkg::CFG_W-1:0]       line_length
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH) + 1;
    localparam int CW    = (LEN_W > ifd_pkg::CFG_W) ? LEN_W : ifd_pkg::CFG_W;
    localparam int FW    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int DW    = (ifd_pkg::DLY_W > LEN_W + FRAC_BITS) ?
                           ifd_pkg::DLY_W : LEN_W + FRAC_BITS;
    localparam int AW    = LEN_W + 1;

    localparam logic [DW-1:0] FRAC_MASK = DW'((2 ** FRAC_BITS) - 1);

    ifd_pkg::state_t state_reg, state_next;

    logic [ifd_pkg::CFG_W-1:0] cfg_reg;
    logic [PTR_W-1:0]          wp_reg, wp_next;
    logic [PTR_W-1:0]          clr_reg, clr_next;
    logic                      out_valid_reg, out_valid_next;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] g_reg;
    logic [PTR_W-1:0]              whole_reg;
    logic [FW-1:0]                 frac_reg;
    logic [PTR_W-1:0]              nx_reg;
    logic signed [SAMPLE_BITS-1:0] delayed_sample_reg;
    logic signed [SAMPLE_BITS-1:0] rdata_reg;

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

    logic [CW-1:0]    cfg_ext;
    logic [LEN_W-1:0] len_eff;
    logic [DW-1:0]    lim;
    logic [DW-1:0]    dly_ext;
    logic [DW-1:0]    dly_sat;
    logic [PTR_W-1:0] wp_adj;
    logic [AW-1:0]    rd_sum;
    logic [AW-1:0]    rd_full;
    logic [PTR_W-1:0] rd;
    logic [LEN_W-1:0] nx_full;
    logic [PTR_W-1:0] nx;
    logic [LEN_W-1:0] wp_inc;
    logic [PTR_W-1:0] raddr;
    logic [PTR_W-1:0] waddr;
    logic signed [SAMPLE_BITS-1:0] wdata;

    logic                 in_fire;
    logic                 out_free;
    logic                 out_load;
    logic                 mem_we;
    logic                 clear_last;
    ifd_pkg::arith_ctl_t  ctl;

    logic signed [SAMPLE_BITS-1:0] o;
    logic signed [SAMPLE_BITS-1:0] w;

    assign cfg_ready  = 1'b1;
    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign clear_last = (clr_reg == PTR_W'(DEPTH - 1));

    // Effective line length
    always_comb
    begin
        cfg_ext = CW'(cfg_reg);
        if (cfg_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (cfg_ext > CW'(DEPTH))
        begin
            len_eff = LEN_W'(DEPTH);
        end
        else
        begin
            len_eff = LEN_W'(cfg_ext);
        end
    end

    // Clamp the delay and drop a stale write pointer at acceptance
    always_comb
    begin
        lim     = DW'(len_eff) << FRAC_BITS;
        dly_ext = DW'(delay_samples);
        dly_sat = (dly_ext >= lim) ? (lim - DW'(1)) : dly_ext;
        wp_adj  = (LEN_W'(wp_reg) >= len_eff) ? '0 : wp_reg;
    end

    // Read entry and its neighbor, modulo the line length
    always_comb
    begin
        rd_sum  = AW'(wp_reg) + AW'(len_eff) - AW'(whole_reg);
        rd_full = (rd_sum >= AW'(len_eff)) ? (rd_sum - AW'(len_eff)) : rd_sum;
        rd      = PTR_W'(rd_full);
        nx_full = LEN_W'(rd) + LEN_W'(1);
        nx      = (nx_full == len_eff) ? '0 : PTR_W'(nx_full);
        wp_inc  = LEN_W'(wp_reg) + LEN_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ifd_pkg::S_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ifd_pkg::S_IDLE;
                end
            end
            ifd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ifd_pkg::S_RD1;
                end
            end
            ifd_pkg::S_RD1:    state_next = ifd_pkg::S_RD2;
            ifd_pkg::S_RD2:    state_next = ifd_pkg::S_INTERP;
            ifd_pkg::S_INTERP: state_next = ifd_pkg::S_MIX;
            ifd_pkg::S_MIX:    state_next = ifd_pkg::S_FB;
            ifd_pkg::S_FB:     state_next = ifd_pkg::S_WB;
            ifd_pkg::S_WB:
            begin
                if (out_free)
                begin
                    state_next = ifd_pkg::S_IDLE;
                end
            end
            default:           state_next = ifd_pkg::S_CLEAR;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        mem_we      = 1'b0;
        out_load    = 1'b0;
        ctl         = '0;
        raddr       = rd;
        waddr       = wp_reg;
        wdata       = w;
        case (state_reg)
            ifd_pkg::S_CLEAR:
            begin
                mem_we = 1'b1;
                waddr  = clr_reg;
                wdata  = '0;
            end
            ifd_pkg::S_IDLE:   in_ready    = 1'b1;
            ifd_pkg::S_RD1:    raddr       = rd;
            ifd_pkg::S_RD2:
            begin
                raddr     = nx_reg;
                ctl.ld_s1 = 1'b1;
            end
            ifd_pkg::S_INTERP: ctl.ld_prod = 1'b1;
            ifd_pkg::S_MIX:    ctl.ld_o    = 1'b1;
            ifd_pkg::S_FB:     ctl.ld_fb   = 1'b1;
            ifd_pkg::S_WB:
            begin
                mem_we   = out_free;
                out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        clr_next       = (state_reg == ifd_pkg::S_CLEAR) ? (clr_reg + PTR_W'(1)) : clr_reg;
        wp_next        = wp_reg;
        if (in_fire)
        begin
            wp_next = wp_adj;
        end
        else if (out_load)
        begin
            wp_next = (wp_inc == len_eff) ? '0 : PTR_W'(wp_inc);
        end
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ifd_pkg::S_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            cfg_reg       <= ifd_pkg::LINE_LENGTH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= line_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg     <= in_sample;
            g_reg     <= feedback_gain;
            whole_reg <= PTR_W'(dly_sat >> FRAC_BITS);
            frac_reg  <= FW'(dly_sat & FRAC_MASK);
        end
        if (state_reg == ifd_pkg::S_RD1)
        begin
            nx_reg <= nx;
        end
        if (out_load)
        begin
            delayed_sample_reg <= o;
        end
    end

    // Delay store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    ifd_arith #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_arith (
        .clk     (clk),
        .ctl     (ctl),
        .rd_data (rdata_reg),
        .x       (x_reg),
        .g       (g_reg),
        .frac    (frac_reg),
        .o       (o),
        .w       (w)
    );

    assign out_valid      = out_valid_reg;
    assign delayed_sample = delayed_sample_reg;

    a_rd_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ifd_pkg::S_RD1) |-> (LEN_W'(rd) < len_eff))
        else $error("read entry outside the line");

    a_nx_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ifd_pkg::S_RD2) |-> (LEN_W'(nx_reg) < len_eff))
        else $error("neighbor entry outside the line");

    a_wb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ifd_pkg::S_WB && !out_free) |=>
        (state_reg == ifd_pkg::S_WB && $stable(wp_reg)))
        else $error("write-back advanced while the output was blocked");

endmodule

FILE: rtl/ifd_arith.sv
`timescale 1ns / 1ps

module ifd_arith #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8,
    localparam int FW         = (FRAC_BITS > 0) ? FRAC_BITS : 1
) (
    input  logic                          clk,
    input  ifd_pkg::arith_ctl_t           ctl,
    input  logic signed [SAMPLE_BITS-1:0] rd_data,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] g,
    input  logic        [FW-1:0]          frac,
    output logic signed [SAMPLE_BITS-1:0] o,
    output logic signed [SAMPLE_BITS-1:0] w
);

    localparam int SB = SAMPLE_BITS;
    localparam int DW = SB + 1;
    localparam int PW = FW + 1 + DW;
    localparam int OW = PW + 1;
    localparam int MW = 2 * SB;
    localparam int WW = SB + 2;

    localparam logic signed [PW-1:0] HALF  = PW'((2 ** FRAC_BITS) / 2);
    localparam logic signed [OW-1:0] O_MAX = {{(OW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [OW-1:0] O_MIN = {{(OW-SB+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic signed [MW-1:0] F_HALF = {{(SB+1){1'b0}}, 1'b1, {(SB-2){1'b0}}};
    localparam logic signed [WW-1:0] W_MAX = {3'b000, {(SB-1){1'b1}}};
    localparam logic signed [WW-1:0] W_MIN = {3'b111, {(SB-1){1'b0}}};

    logic signed [SB-1:0] s1_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [SB-1:0] o_reg;
    logic signed [MW-1:0] fbp_reg;

    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] step;
    logic signed [OW-1:0] o_wide;
    logic signed [SB-1:0] o_next;
    logic signed [MW-1:0] fbp;
    logic signed [MW-1:0] fb;
    logic signed [WW-1:0] w_wide;

    always_comb
    begin
        diff = DW'(rd_data) - DW'(s1_reg);
        prod = $signed({1'b0, frac}) * diff;
    end

    // Round half up, then clamp the interpolated sample
    always_comb
    begin
        step   = (prod_reg + HALF) >>> FRAC_BITS;
        o_wide = OW'(s1_reg) + OW'(step);
        if (o_wide > O_MAX)
        begin
            o_next = SB'(O_MAX);
        end
        else if (o_wide < O_MIN)
        begin
            o_next = SB'(O_MIN);
        end
        else
        begin
            o_next = SB'(o_wide);
        end
    end

    assign fbp = o_reg * g;

    always_comb
    begin
        fb     = (fbp_reg + F_HALF) >>> (SB - 1);
        w_wide = WW'(x) + WW'(fb);
        if (w_wide > W_MAX)
        begin
            w = SB'(W_MAX);
        end
        else if (w_wide < W_MIN)
        begin
            w = SB'(W_MIN);
        end
        else
        begin
            w = SB'(w_wide);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_s1)
        begin
            s1_reg <= rd_data;
        end
        if (ctl.ld_prod)
        begin
            prod_reg <= prod;
        end
        if (ctl.ld_o)
        begin
            o_reg <= o_next;
        end
        if (ctl.ld_fb)
        begin
            fbp_reg <= fbp;
        end
    end

    assign o = o_reg;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int SB           = 16;
    localparam int LINE_DEPTH   = 4096;
    localparam int LINE_AW      = $clog2(LINE_DEPTH);
    localparam int LIMIT_CYCLES = 600000;
    localparam int MAX_REPORTS  = 10;

    logic                         clk            = 1'b0;
    logic                         rst_n          = 1'b0;
    logic                         in_valid       = 1'b0;
    logic                         in_ready;
    logic signed [SB-1:0]         in_sample      = '0;
    logic [ifd_pkg::DLY_W-1:0]    delay_samples  = '0;
    logic signed [SB-1:0]         feedback_gain  = '0;
    logic                         out_valid;
    logic                         out_ready      = 1'b0;
    logic signed [SB-1:0]         delayed_sample;
    logic                         cfg_valid      = 1'b0;
    logic                         cfg_ready;
    logic [ifd_pkg::CFG_W-1:0]    line_length    = '0;

    interpolated_feedback_delay_unit #(
        .DEPTH       (LINE_DEPTH),
        .FRAC_BITS   (8),
        .SAMPLE_BITS (SB)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_sample      (in_sample),
        .delay_samples  (delay_samples),
        .feedback_gain  (feedback_gain),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .delayed_sample (delayed_sample),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .line_length    (line_length)
    );

    // Mirror of the delay line
    logic signed [SB-1:0]      line_mem [LINE_DEPTH];
    int unsigned               line_wr_ptr;
    logic [ifd_pkg::CFG_W-1:0] line_len_cfg;
    logic signed [SB-1:0]      pending_echo [$];

    bit tx_fast = 1'b0;
    bit rx_fast = 1'b0;
    bit rx_hold = 1'b0;
    int words_sent    = 0;
    int words_checked = 0;
    int mismatches    = 0;
    int len_settings  = 0;
    int cycle_count   = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("interpolated_feedback_delay_unit verification failed");
            $finish;
        end
    end

    function automatic int unsigned eff_length(logic [ifd_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > LINE_DEPTH)
            return LINE_DEPTH;
        return 32'(v);
    endfunction

    function automatic logic signed [SB-1:0] clip_q15(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[SB-1:0];
    endfunction

    // Interpolated read, then feedback write-back; queue the output sample
    function automatic void predict_echo(logic signed [SB-1:0] x,
                                         logic [ifd_pkg::DLY_W-1:0] d,
                                         logic signed [SB-1:0] g);
        int unsigned          len;
        int unsigned          whole;
        int unsigned          rd;
        int unsigned          nx;
        longint               dly;
        longint               frac;
        longint               s1;
        longint               s2;
        longint               xs;
        longint               gs;
        longint               os;
        longint               fb;
        logic signed [SB-1:0] o16;
        len = eff_length(line_len_cfg);
        if (line_wr_ptr >= len)
            line_wr_ptr = 0;
        dly = longint'(d);
        if (dly >= (longint'(len) << 8))
            dly = (longint'(len) << 8) - 1;
        whole = 32'(dly >> 8);
        frac  = dly & 255;
        rd = (line_wr_ptr + len - whole) % len;
        nx = (rd + 1) % len;
        s1 = longint'(line_mem[LINE_AW'(rd)]);
        s2 = longint'(line_mem[LINE_AW'(nx)]);
        o16 = clip_q15(s1 + ((frac * (s2 - s1) + 128) >>> 8));
        os = longint'(o16);
        xs = longint'(x);
        gs = longint'(g);
        fb = (os * gs + 16384) >>> 15;
        line_mem[LINE_AW'(line_wr_ptr)] = clip_q15(xs + fb);
        line_wr_ptr = (line_wr_ptr + 1) % len;
        pending_echo.push_back(o16);
    endfunction

    function automatic logic signed [SB-1:0] rand_q15();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return r[SB-1:0];
        endcase
    endfunction

    // Half are short delays that hit recent writes; a quarter span the line, a quarter are raw
    function automatic logic [ifd_pkg::DLY_W-1:0] rand_delay(int unsigned len);
        logic [31:0] r;
        logic [11:0] whole;
        r = $urandom;
        case ($urandom_range(0, 3))
            0, 1:    whole = 12'($urandom_range(0, (len < 64 ? len : 64) - 1));
            2:       whole = 12'($urandom_range(0, len - 1));
            default: return r[ifd_pkg::DLY_W-1:0];
        endcase
        return {whole, r[7:0]};
    endfunction

    task send_word(input logic signed [SB-1:0] x, input logic [ifd_pkg::DLY_W-1:0] d,
                   input logic signed [SB-1:0] g);
        int gap;
        gap = tx_fast ? 0 : int'($urandom_range(0, 7));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_sample     <= x;
        delay_samples <= d;
        feedback_gain <= g;
        do @(posedge clk); while (!in_ready);
        predict_echo(x, d, g);
        words_sent++;
    endtask

    task write_line_length(input logic [ifd_pkg::CFG_W-1:0] v);
        cfg_valid   <= 1'b1;
        line_length <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        line_len_cfg  = v;
        len_settings++;
    endtask

    // Drop valid, let every outstanding word arrive, then let the pipeline settle
    task wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_echo.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    initial
    begin
        int                   stall;
        logic signed [SB-1:0] expected;
        @(posedge clk);
        forever
        begin
            stall = rx_fast ? 0 : int'($urandom_range(0, 7));
            while (stall > 0 || rx_hold)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
                if (stall > 0)
                    stall--;
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_echo.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("delayed_sample %0d arrived with nothing outstanding",
                             delayed_sample);
            end
            else
            begin
                expected = pending_echo.pop_front();
                words_checked++;
                if (delayed_sample !== expected)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word %0d: delayed_sample expected %0d, got %0d",
                                 words_checked, expected, delayed_sample);
                end
            end
        end
    end

    // Short line so saturation and interpolation show up on the first pass
    task test_interp_and_saturation();
        wait_drained();
        write_line_length(13'd4);
        send_word(16'sh7FFF, 20'h00000, 16'sh7FFF);
        send_word(16'sh8000, 20'h00100, 16'sh8000);
        send_word(16'sh7FFF, 20'h00100, 16'sh8000);
        send_word(-16'sd1, 20'h00180, 16'sh7FFF);
        send_word(16'sh0000, 20'h000FF, -16'sd1);
        send_word(16'sd100, 20'hFFFFF, 16'sh4000);
        send_word(-16'sd100, 20'h00400, 16'sh7FFF);
        send_word(16'sh5555, 20'h00355, 16'shAAAA);
    endtask

    // Lower the line below the write pointer
    task test_stale_pointer();
        wait_drained();
        write_line_length(13'd50);
        repeat (7) send_word(rand_q15(), rand_delay(50), rand_q15());
        wait_drained();
        write_line_length(13'd3);
        send_word(rand_q15(), 20'h00000, rand_q15());
        send_word(rand_q15(), 20'h00180, rand_q15());
        send_word(rand_q15(), 20'h002FF, rand_q15());
    endtask

    task test_length_limits();
        wait_drained();
        write_line_length(13'd0);
        send_word(16'sh1234, 20'h000FF, 16'sh7FFF);
        send_word(16'sh8000, 20'hFFFFF, 16'sh8000);
        wait_drained();
        write_line_length(13'h1FFF);
        send_word(16'sh7FFF, 20'hFFFFF, 16'sh8000);
        send_word(16'sh8000, 20'h00000, 16'sh7FFF);
    endtask

    task random_phase(input logic [ifd_pkg::CFG_W-1:0] len_val, input int count);
        int unsigned len;
        wait_drained();
        write_line_length(len_val);
        len = eff_length(len_val);
        for (int i = 0; i < count; i++)
        begin
            // hold a stretch of back-to-back traffic on both sides
            tx_fast = (i >= count / 3) && (i < count / 2);
            rx_fast = tx_fast;
            send_word(rand_q15(), rand_delay(len), rand_q15());
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;
    endtask

    task test_random_lengths();
        random_phase(13'd1, 100);
        random_phase(13'd2, 100);
        random_phase(13'd5, 150);
        random_phase(13'd16, 170);
        random_phase(13'd37, 200);
        random_phase(13'd255, 200);
        random_phase(13'd4096, 150);
        random_phase(13'd4095, 100);
        random_phase(13'd4097, 80);
        random_phase(13'h1FFF, 80);
        random_phase(13'd0, 60);
        random_phase(13'($urandom_range(1, 300)), 120);
        random_phase(13'($urandom_range(1, 300)), 120);
        random_phase(13'($urandom_range(1, 8191)), 100);
    endtask

    // Stall the output long enough that the input backs up
    task test_backpressure();
        wait_drained();
        write_line_length(13'd24);
        tx_fast = 1'b1;
        fork
            hold_receiver(400);
        join_none
        repeat (30) send_word(rand_q15(), rand_delay(24), rand_q15());
        tx_fast = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        foreach (line_mem[i])
            line_mem[i] = '0;
        line_wr_ptr  = 0;
        line_len_cfg = ifd_pkg::LINE_LENGTH_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_interp_and_saturation();
        test_stale_pointer();
        test_length_limits();
        test_random_lengths();
        test_backpressure();
        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_echo.size() != 0)
        begin
            mismatches += pending_echo.size();
            $display("%0d expected words never arrived", pending_echo.size());
        end
        $display("Ran %0d samples over %0d line length settings (0, 1, 4096, above depth)",
                 words_sent, len_settings);
        $display("with random stalls and a long output hold; %0d words compared, %0d errors",
                 words_checked, mismatches);
        if (mismatches == 0)
            $display("interpolated_feedback_delay_unit verification clean");
        else
            $display("interpolated_feedback_delay_unit verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ifd_pkg.sv
rtl/ifd_arith.sv
rtl/interpolated_feedback_delay_unit.sv
verif/tb_top.sv
